// ===== sv/assert_macros.svh =====
// Assertion helpers; each expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every edge outside reset
`define ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");

// Consequent holds in the same cycle as the antecedent
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== sv/tdn_pkg.sv =====
package tdn_pkg;

  localparam int MAX_KEYS = 128;
  localparam int IDX_W    = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
  localparam int CNT_W    = $clog2(MAX_KEYS + 1);
  localparam int OFS_W    = 16;
  localparam int KEY_W    = 4 * OFS_W;
  localparam int ID_W     = 7;
  localparam int DCNT_W   = 8;

  // Search request travelling down the cell row
  typedef struct packed {
    logic             vld;
    logic [KEY_W-1:0] key;
    logic             hit;
    logic [IDX_W-1:0] id;
  } probe_t;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic              is_new;
    logic [DCNT_W-1:0] dcount;
    logic              full;
    logic              seq_end;
  } result_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_HOLD
  } state_t;

endpackage

// ===== sv/tdn_cell.sv =====
module tdn_cell (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [tdn_pkg::IDX_W-1:0]  idx,
  input  logic [tdn_pkg::CNT_W-1:0]  cnt,
  input  tdn_pkg::probe_t            probe_in,
  output tdn_pkg::probe_t            probe_out
);
  import tdn_pkg::*;

  logic [KEY_W-1:0] key_r;
  probe_t           probe_r;
  probe_t           probe_nxt;
  logic             occupied;
  logic             match;
  logic             wr;

  assign occupied = CNT_W'(idx) < cnt;
  assign match    = probe_in.vld && !probe_in.hit && occupied && (key_r == probe_in.key);
  // First free slot takes the key when nothing earlier matched
  assign wr       = probe_in.vld && !probe_in.hit && (CNT_W'(idx) == cnt);

  always_comb begin
    probe_nxt     = probe_in;
    probe_nxt.hit = probe_in.hit | match;
    if (match) begin
      probe_nxt.id = idx;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      key_r <= probe_in.key;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      probe_r.vld <= 1'b0;
    end else begin
      probe_r.vld <= probe_nxt.vld;
    end
    probe_r.key <= probe_nxt.key;
    probe_r.hit <= probe_nxt.hit;
    probe_r.id  <= probe_nxt.id;
  end

  assign probe_out = probe_r;

endmodule

// ===== sv/track_tuple_dedup_numbering.sv =====
// Dense numbering of distinct four-offset keys within a sequence.
// Input channel: in_valid / in_stall with four 16-bit track offsets and
// in_last_position. Result channel: out_valid / out_stall with pattern
// number, new-key flag, running distinct count, store-full flag and a
// copy of the last-position marker. One result per input, in order.
// Each accepted key is sent down a row of MAX_KEYS cells, one cell per
// cycle; every cell holds one stored key, compares it, and the first free
// cell stores a key that nothing earlier matched. out_valid rises once the
// probe has left the row and its result is registered; one item is in
// work at a time, so the next input is not accepted until the result of
// the last one has been formed.
// A result waits in the output register while out_stall is high; the next
// item may be accepted meanwhile, and its finished result is held inside
// until the output register frees, with in_stall high in that time.
// The item marked last resets the distinct count once its result is formed.
// Reset (rst_n low, synchronous) holds in_stall high, empties the store and
// drops any result; stored keys are not cleared, only the count of entries.
`include "assert_macros.svh"

module track_tuple_dedup_numbering (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [tdn_pkg::OFS_W-1:0]   in_track_offset_a,
  input  logic [tdn_pkg::OFS_W-1:0]   in_track_offset_b,
  input  logic [tdn_pkg::OFS_W-1:0]   in_track_offset_c,
  input  logic [tdn_pkg::OFS_W-1:0]   in_track_offset_d,
  input  logic                        in_last_position,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [tdn_pkg::ID_W-1:0]    out_pattern_id,
  output logic                        out_is_new,
  output logic [tdn_pkg::DCNT_W-1:0]  out_distinct_count,
  output logic                        out_store_full,
  output logic                        out_sequence_end
);
  import tdn_pkg::*;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic             last_r;
  probe_t           probe_r;
  probe_t           chain [MAX_KEYS+1];
  probe_t           tail;
  result_t          res_calc;
  result_t          hold_r;
  result_t          out_r;
  logic             out_valid_r;
  logic             out_free;
  logic             accept;
  logic             load_out;
  logic             load_hold;
  logic             load_sel_hold;
  logic [CNT_W-1:0] cnt_after;
  logic             new_key;

  assign chain[0] = probe_r;
  assign tail     = chain[MAX_KEYS];

  for (genvar g = 0; g < MAX_KEYS; g++) begin : g_cell
    tdn_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .idx       (IDX_W'(g)),
      .cnt       (cnt_r),
      .probe_in  (chain[g]),
      .probe_out (chain[g+1])
    );
  end

  // Outcome once the probe leaves the row
  always_comb begin
    res_calc.seq_end = last_r;
    res_calc.full    = 1'b0;
    if (tail.hit) begin
      res_calc.id     = ID_W'(tail.id);
      res_calc.is_new = 1'b0;
      cnt_after       = cnt_r;
    end else if (cnt_r != CNT_W'(MAX_KEYS)) begin
      res_calc.id     = ID_W'(cnt_r);
      res_calc.is_new = 1'b1;
      cnt_after       = cnt_r + 1'b1;
    end else begin
      res_calc.id     = '0;
      res_calc.is_new = 1'b1;
      res_calc.full   = 1'b1;
      cnt_after       = cnt_r;
    end
    res_calc.dcount = DCNT_W'(cnt_after);
  end

  assign new_key  = tail.vld && !tail.hit && (cnt_r != CNT_W'(MAX_KEYS));
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    in_stall      = 1'b1;
    accept        = 1'b0;
    load_out      = 1'b0;
    load_hold     = 1'b0;
    load_sel_hold = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_stall = !rst_n;
        if (in_valid && rst_n) begin
          accept    = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (tail.vld) begin
          if (out_free) begin
            load_out  = 1'b1;
            state_nxt = ST_IDLE;
          end else begin
            load_hold = 1'b1;
            state_nxt = ST_HOLD;
          end
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          load_out      = 1'b1;
          load_sel_hold = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      if (tail.vld) begin
        cnt_r <= last_r ? '0 : cnt_after;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      probe_r.vld <= 1'b0;
    end else begin
      probe_r.vld <= accept;
    end
    if (accept) begin
      probe_r.key <= {in_track_offset_d, in_track_offset_c,
                      in_track_offset_b, in_track_offset_a};
      probe_r.hit <= 1'b0;
      probe_r.id  <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      last_r <= in_last_position;
    end
    if (load_hold) begin
      hold_r <= res_calc;
    end
    if (load_out) begin
      out_r <= load_sel_hold ? hold_r : res_calc;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_pattern_id     = out_r.id;
  assign out_is_new         = out_r.is_new;
  assign out_distinct_count = out_r.dcount;
  assign out_store_full     = out_r.full;
  assign out_sequence_end   = out_r.seq_end;

  `ASSERT_ALWAYS(a_cnt_bound, cnt_r <= CNT_W'(MAX_KEYS))
  `ASSERT_IMPL(a_tail_in_scan, tail.vld, state_r == ST_SCAN)
  `ASSERT_NEXT(a_cnt_grow, new_key && !last_r, cnt_r == CNT_W'($past(cnt_r) + 1'b1))
  `ASSERT_IMPL(a_full_is_new, out_valid_r && out_r.full, out_r.is_new)

endmodule

// ===== test/tb_track_tuple_dedup_numbering.sv =====
`timescale 1ns / 1ps

module tb_track_tuple_dedup_numbering;
  import tdn_pkg::*;

  localparam int TOTAL_POSITIONS = 1200;
  localparam int IDLE_LIMIT      = 4000;
  localparam int HOLDOFF_CYCLES  = 400;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [OFS_W-1:0]  in_track_offset_a;
  logic [OFS_W-1:0]  in_track_offset_b;
  logic [OFS_W-1:0]  in_track_offset_c;
  logic [OFS_W-1:0]  in_track_offset_d;
  logic              in_last_position;
  logic              out_valid;
  logic              out_stall;
  logic [ID_W-1:0]   out_pattern_id;
  logic              out_is_new;
  logic [DCNT_W-1:0] out_distinct_count;
  logic              out_store_full;
  logic              out_sequence_end;

  track_tuple_dedup_numbering u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_track_offset_a  (in_track_offset_a),
    .in_track_offset_b  (in_track_offset_b),
    .in_track_offset_c  (in_track_offset_c),
    .in_track_offset_d  (in_track_offset_d),
    .in_last_position   (in_last_position),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_pattern_id     (out_pattern_id),
    .out_is_new         (out_is_new),
    .out_distinct_count (out_distinct_count),
    .out_store_full     (out_store_full),
    .out_sequence_end   (out_sequence_end)
  );

  // Keeps its own copy of the distinct keys of the open sequence and the
  // numbers that each accepted position should come back with.
  class pattern_number_checker;
    logic [KEY_W-1:0] known_keys [MAX_KEYS];
    int unsigned      known_count;
    result_t          awaited_numbers [$];
    int unsigned      failures;
    int unsigned      positions;
    int unsigned      repeats;
    int unsigned      overflows;
    int unsigned      sequences;
    int unsigned      checked;

    function void note_position(logic [KEY_W-1:0] key, logic last_pos);
      result_t want;
      int      slot;
      slot = -1;
      for (int i = 0; i < known_count; i++)
        if (known_keys[i] == key) begin
          slot = i;
          break;
        end
      want = '0;
      want.seq_end = last_pos;
      if (slot >= 0) begin
        want.id = ID_W'(slot);
        repeats++;
      end else begin
        want.is_new = 1'b1;
        if (known_count < MAX_KEYS) begin
          known_keys[known_count] = key;
          want.id = ID_W'(known_count);
          known_count++;
        end else begin
          // no room: number stays 0, count unchanged
          want.full = 1'b1;
          overflows++;
        end
      end
      want.dcount = DCNT_W'(known_count);
      awaited_numbers.push_back(want);
      positions++;
      if (last_pos) begin
        known_count = 0;
        sequences++;
      end
    endfunction

    function void compare_field(string field, logic [7:0] want_v, logic [7:0] got_v);
      if (got_v !== want_v) begin
        $error("%s: expected %0d, actual %0d", field, want_v, got_v);
        failures++;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (awaited_numbers.size() == 0) begin
        $error("result transfer with no position waiting (pattern_id %0d)", got.id);
        failures++;
        return;
      end
      want = awaited_numbers.pop_front();
      checked++;
      compare_field("pattern_id", 8'(want.id), 8'(got.id));
      compare_field("is_new", 8'(want.is_new), 8'(got.is_new));
      compare_field("distinct_count", 8'(want.dcount), 8'(got.dcount));
      compare_field("store_full", 8'(want.full), 8'(got.full));
      compare_field("sequence_end", 8'(want.seq_end), 8'(got.seq_end));
    endfunction

    function void close_out();
      if (awaited_numbers.size() != 0) begin
        $error("%0d results never arrived", awaited_numbers.size());
        failures++;
      end
    endfunction
  endclass

  pattern_number_checker numbering = new;

  int unsigned items_sent;
  int unsigned burst_left;
  int unsigned holdoff_asks;
  int unsigned holdoffs_done;
  int unsigned idle_cycles;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Note every transfer on both channels
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall)
        numbering.note_position({in_track_offset_d, in_track_offset_c,
                                 in_track_offset_b, in_track_offset_a}, in_last_position);
      if (out_valid && !out_stall)
        numbering.check_result('{id: out_pattern_id, is_new: out_is_new,
                                 dcount: out_distinct_count, full: out_store_full,
                                 seq_end: out_sequence_end});
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles <= 0;
    else if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
      $display("Some tests failed");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

  // Receiver: stall pattern changes mode now and then; a requested hold-off
  // keeps out_stall high long enough for the block to back up.
  initial begin
    int unsigned cyc;
    int unsigned stall_mode;
    out_stall = 1'b0;
    holdoffs_done = 0;
    cyc = 0;
    stall_mode = 0;
    forever begin
      @(negedge clk);
      if (holdoff_asks != holdoffs_done) begin
        holdoffs_done++;
        out_stall = 1'b1;
        repeat (HOLDOFF_CYCLES) @(negedge clk);
      end
      cyc++;
      if (cyc % 97 == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
        0:       out_stall = 1'b0;
        1:       out_stall = ($urandom_range(0, 3) == 0);
        2:       out_stall = ($urandom_range(0, 3) != 0);
        default: out_stall = cyc[2];
      endcase
    end
  end

  // Call at a falling edge; returns at the falling edge after the transfer,
  // having dropped valid for a gap when the burst is over and the gap drawn is not zero.
  task automatic send_position(input logic [KEY_W-1:0] key, input logic last_pos);
    int unsigned gap;
    in_valid          = 1'b1;
    in_track_offset_a = key[0*OFS_W +: OFS_W];
    in_track_offset_b = key[1*OFS_W +: OFS_W];
    in_track_offset_c = key[2*OFS_W +: OFS_W];
    in_track_offset_d = key[3*OFS_W +: OFS_W];
    in_last_position  = last_pos;
    do @(posedge clk); while (in_stall !== 1'b0);
    @(negedge clk);
    items_sent++;
    if (burst_left > 0)
      burst_left--;
    else begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 200) : $urandom_range(0, 3);
      if (gap > 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 6);
    end
  endtask

  task automatic wait_for_results();
    in_valid = 1'b0;
    while (numbering.awaited_numbers.size() != 0) @(negedge clk);
  endtask

  function automatic logic [KEY_W-1:0] make_key(input logic [KEY_W-1:0] near);
    logic [KEY_W-1:0] k;
    k = {$urandom, $urandom};
    case ($urandom_range(0, 3))
      0: k = near ^ (64'h1 << $urandom_range(0, KEY_W - 1));
      1: for (int f = 0; f < 4; f++)
           case ($urandom_range(0, 2))
             0:       k[f*OFS_W +: OFS_W] = '0;
             1:       k[f*OFS_W +: OFS_W] = '1;
             default: k[f*OFS_W +: OFS_W] = OFS_W'($urandom);
           endcase
      default: ;
    endcase
    return k;
  endfunction

  // Fill the store to the top, then offer repeats and keys with no room left
  task automatic run_fill();
    logic [KEY_W-1:0] filled [$];
    logic [KEY_W-1:0] k;
    for (int i = 0; i < MAX_KEYS; i++) begin
      k = {$urandom, $urandom};
      k[OFS_W-1:0] = OFS_W'(i);
      filled.push_back(k);
      send_position(k, 1'b0);
    end
    send_position(filled[MAX_KEYS-1], 1'b0);
    send_position(~filled[0], 1'b0);
    send_position(filled[0], 1'b0);
    k = {$urandom, $urandom};
    k[OFS_W-1] = 1'b1;
    send_position(k, 1'b0);
    send_position(filled[MAX_KEYS/2], 1'b0);
    k[OFS_W-2] = ~k[OFS_W-2];
    send_position(k, 1'b1);
  endtask

  // Mostly well-formed sequences over a pool of related keys; a stray early
  // end now and then breaks one off.
  task automatic run_sequence(input bit long_run);
    logic [KEY_W-1:0] pool [$];
    logic [KEY_W-1:0] k;
    logic             last_pos;
    int               pool_size;
    int               len;
    int               fresh;
    pool_size = long_run ? MAX_KEYS + $urandom_range(2, 12) : $urandom_range(1, 12);
    len = long_run ? pool_size + $urandom_range(30, 50) : $urandom_range(1, 24);
    for (int i = 0; i < pool_size; i++)
      pool.push_back(make_key(i == 0 ? {$urandom, $urandom} : pool[i-1]));
    fresh = 0;
    for (int p = 0; p < len; p++) begin
      if (fresh == 0 ||
          (fresh < pool_size && $urandom_range(0, 7) < (long_run ? 7 : 4))) begin
        k = pool[fresh];
        fresh++;
      end else
        k = pool[$urandom_range(0, fresh - 1)];
      last_pos = (p == len - 1) || ($urandom_range(0, 59) == 0);
      send_position(k, last_pos);
    end
  endtask

  initial begin
    int unsigned seq_no;
    rst_n             = 1'b0;
    in_valid          = 1'b0;
    in_track_offset_a = '0;
    in_track_offset_b = '0;
    in_track_offset_c = '0;
    in_track_offset_d = '0;
    in_last_position  = 1'b0;
    items_sent        = 0;
    burst_left        = 0;
    holdoff_asks      = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: extremes, one-bit neighbours in every channel, repeats, ends
    send_position('0, 1'b0);
    send_position('0, 1'b0);
    send_position('1, 1'b0);
    for (int f = 0; f < 4; f++) begin
      send_position(64'h1 << (OFS_W * f), 1'b0);
      send_position(64'h8000 << (OFS_W * f), 1'b0);
    end
    send_position(64'hFFFF_FFFF_FFFF_0000, 1'b0);
    send_position(64'h0000_FFFF_FFFF_FFFF, 1'b0);
    send_position('1, 1'b0);
    send_position(64'h8000_0000, 1'b0);
    send_position('0, 1'b1);
    send_position('0, 1'b1);
    send_position('1, 1'b0);
    send_position(64'h1234_5678_9ABC_DEF0, 1'b1);
    wait_for_results();

    run_fill();
    wait_for_results();

    seq_no = 0;
    while (items_sent < TOTAL_POSITIONS) begin
      if (seq_no % 10 == 3) begin
        holdoff_asks++;
        burst_left = 8;
      end
      if (seq_no % 10 == 7) wait_for_results();
      run_sequence($urandom_range(0, 11) == 0);
      seq_no++;
    end

    wait_for_results();
    repeat (MAX_KEYS + 22) @(negedge clk);
    numbering.close_out();
    $display("Sent %0d positions in %0d closed sequences: %0d repeated keys, %0d store-full",
             numbering.positions, numbering.sequences, numbering.repeats, numbering.overflows);
    $display("%0d results compared, %0d long receiver hold-offs, %0d failures",
             numbering.checked, holdoffs_done, numbering.failures);
    if (numbering.failures == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
